// File: rtl/antialiased_disc_max_blend_raster_top_macros.svh
// Assertion macros used by the raster back end (admr_back).
`ifndef ANTIALIASED_DISC_MAX_BLEND_RASTER_TOP_MACROS_SVH
`define ANTIALIASED_DISC_MAX_BLEND_RASTER_TOP_MACROS_SVH
`ifndef SYNTH
`define ADMR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ADMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ADMR_ASSERT_SAME(lbl, ante, cons)
`define ADMR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/admr_pkg.sv
`timescale 1ns / 1ps
package admr_pkg;
  localparam int SURFACE_SIZE = 384;
  localparam int COORD_W = $clog2(SURFACE_SIZE);
  localparam int ADDR_W = $clog2(SURFACE_SIZE * SURFACE_SIZE);
  localparam int CTR_W = (COORD_W >= 10) ? COORD_W + 2 : 12;
  localparam int SPAN_MIN = 66;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] REG_RADIUS_SCALE = 2'd0;
  localparam logic [1:0] REG_RADIUS_MIN = 2'd1;
  localparam logic [1:0] REG_RADIUS_MAX = 2'd2;
  localparam logic [1:0] REG_BRIGHTNESS_GAIN = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [15:0] center_dx;
    logic signed [15:0] center_dy;
    logic [11:0] disc_radius;
    logic [8:0] intensity;
    logic [8:0] read_col;
    logic [8:0] read_row;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [7:0] pixels_raised;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic [2:0] ext;
    logic [7:0] gray;
    logic [21:0] outer;
    logic [19:0] span;
    logic [8:0] read_col;
    logic [8:0] read_row;
  } cmd_t;
endpackage

// File: rtl/antialiased_disc_max_blend_raster_top.sv
`timescale 1ns / 1ps
// Channel | Handshake          | Payload
// in      | in_valid, in_stall | in_data (in_t)
// out     | out_valid,out_stall| out_data (out_t)
// cfg     | cfg_we             | cfg_index, cfg_data
// A draw passes the front states MUL, CLAMP and PUSH and leaves the queue, then the back
// end visits each window pixel (the bit-serial divider for partly covered pixels), over
// (2*ext+1)^2 pixels, ext <= 7.
// A read result is offered after the front, the queue and the back read state; a clear
// sweeps the canvas at one byte a cycle, over all 147456 bytes.
// After reset the same sweep runs and in_stall stays high until it ends.
// The front and the two-entry queue take up to three more items while a result
// waits on out_stall; after that in_stall stays high.
module antialiased_disc_max_blend_raster_top import admr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  logic [7:0] radius_scale;
  logic [11:0] radius_min;
  logic [10:0] radius_max;
  logic [9:0] brightness_gain;
  logic push;
  cmd_t push_data;
  logic q_full;
  logic pop;
  logic q_valid;
  cmd_t q_data;
  logic init;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_scale <= 8'd210;
      radius_min <= 12'd205;
      radius_max <= 11'd1075;
      brightness_gain <= 10'd320;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS_SCALE: radius_scale <= cfg_data[7:0];
        REG_RADIUS_MIN: radius_min <= cfg_data;
        REG_RADIUS_MAX: radius_max <= cfg_data[10:0];
        REG_BRIGHTNESS_GAIN: brightness_gain <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  admr_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .hold(init), .radius_scale, .radius_min, .radius_max, .brightness_gain,
    .push, .push_data, .q_full
  );

  admr_queue u_queue (
    .clk, .rst, .push, .push_data, .full(q_full), .pop, .q_valid, .q_data
  );

  admr_back u_back (
    .clk, .rst, .q_valid, .q_data, .pop, .init, .out_valid, .out_stall, .out_data
  );
endmodule

// File: rtl/admr_front.sv
`timescale 1ns / 1ps
module admr_front import admr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  input  logic        hold,
  input  logic [7:0]  radius_scale,
  input  logic [11:0] radius_min,
  input  logic [10:0] radius_max,
  input  logic [9:0]  brightness_gain,
  output logic        push,
  output cmd_t        push_data,
  input  logic        q_full
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL = 2'd1;
  localparam logic [1:0] F_CLAMP = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state;
  in_t item;
  logic [19:0] r_prod;
  logic [18:0] b_prod;
  logic [10:0] radius;
  logic [24:0] gray_prod;
  logic [11:0] r_scaled;
  logic [11:0] r_low;
  logic [16:0] b_clamp;
  logic [11:0] r_ext;
  logic signed [CTR_W-1:0] cx;
  logic signed [CTR_W-1:0] cy;

  function automatic logic signed [CTR_W-1:0] to_pixel(input logic signed [15:0] off);
    logic signed [CTR_W+5:0] c;
    logic [CTR_W+5:0] m;
    logic [CTR_W+5:0] p;
    c = (CTR_W+6)'(SURFACE_SIZE * 32) + (CTR_W+6)'(off);
    m = c[CTR_W+5] ? (CTR_W+6)'(-c) : c;
    p = (m + (CTR_W+6)'(32)) >> 6;
    return c[CTR_W+5] ? CTR_W'(-p) : CTR_W'(p);
  endfunction

  assign in_stall = (state != F_IDLE) || hold;
  assign r_scaled = 12'((r_prod + 20'd128) >> 8);
  assign r_low = (r_scaled < radius_min) ? radius_min : r_scaled;
  assign b_clamp = (b_prod > 19'd65536) ? 17'd65536 : b_prod[16:0];
  assign r_ext = {1'b0, radius} + 12'd383;
  assign cx = to_pixel(item.center_dx);
  assign cy = to_pixel(item.center_dy);

  always_comb begin
    push_data.kind = item.kind;
    push_data.cx = cx;
    push_data.cy = cy;
    push_data.ext = r_ext[10:8];
    push_data.gray = 8'((gray_prod + 25'd32768) >> 16);
    push_data.outer = 22'({1'b0, radius} + 12'd128) * 22'({1'b0, radius} + 12'd128);
    push_data.span = ({radius, 9'b0} < 20'(SPAN_MIN)) ? 20'(SPAN_MIN) : {radius, 9'b0};
    push_data.read_col = item.read_col;
    push_data.read_row = item.read_row;
  end

  assign push = (state == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (in_valid && !in_stall) state <= F_MUL;
        F_MUL: state <= F_CLAMP;
        F_CLAMP: state <= F_PUSH;
        F_PUSH: if (!q_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid && !in_stall) item <= in_data;
    if (state == F_MUL) begin
      r_prod <= item.disc_radius * radius_scale;
      b_prod <= item.intensity * brightness_gain;
    end
    if (state == F_CLAMP) begin
      radius <= (r_low > {1'b0, radius_max}) ? radius_max : r_low[10:0];
      gray_prod <= b_clamp * 8'd255;
    end
  end
endmodule

// File: rtl/admr_queue.sv
`timescale 1ns / 1ps
module admr_queue import admr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_data
);
  cmd_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end
endmodule

// File: rtl/admr_back.sv
`timescale 1ns / 1ps
`include "antialiased_disc_max_blend_raster_top_macros.svh"
module admr_back import admr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_data,
  output logic pop,
  output logic init,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR = 3'd1;
  localparam logic [2:0] ST_RD = 3'd2;
  localparam logic [2:0] ST_PIX = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;
  localparam logic [2:0] ST_DIV = 3'd5;
  localparam logic [2:0] ST_WR = 3'd6;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SURFACE_SIZE * SURFACE_SIZE - 1);

  logic [7:0] canvas [SURFACE_SIZE * SURFACE_SIZE];
  logic [2:0] state;
  cmd_t cmd;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [7:0] rd_data;
  logic mem_re;
  logic mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0] wr_val;
  logic signed [3:0] ox;
  logic signed [3:0] oy;
  logic [7:0] count;
  logic [27:0] prod;
  logic full_cov;
  logic [28:0] rem;
  logic [7:0] quot;
  logic [2:0] step;
  logic [7:0] value;
  logic signed [CTR_W:0] px;
  logic signed [CTR_W:0] py;
  logic [6:0] d2;
  logic signed [24:0] num;
  logic in_bounds;
  logic last_pix;
  logic read_ok;
  logic [28:0] trial;
  logic signed [3:0] ext_s;

  assign ext_s = $signed({1'b0, cmd.ext});
  assign px = (CTR_W+1)'(cmd.cx) + (CTR_W+1)'(ox);
  assign py = (CTR_W+1)'(cmd.cy) + (CTR_W+1)'(oy);
  assign d2 = 7'(ox) * 7'(ox) + 7'(oy) * 7'(oy);
  assign num = $signed({3'b0, cmd.outer}) - $signed({2'b0, d2, 16'b0});
  assign in_bounds = (px >= 0) && (px < SURFACE_SIZE) && (py >= 0) && (py < SURFACE_SIZE);
  assign pix_addr = ADDR_W'(py[COORD_W-1:0] * SURFACE_SIZE) + ADDR_W'(px[COORD_W-1:0]);
  assign last_pix = (ox == ext_s) && (oy == ext_s);
  assign read_ok = (q_data.read_col < SURFACE_SIZE) && (q_data.read_row < SURFACE_SIZE);
  assign trial = 29'({8'b0, cmd.span, 1'b0} << step);
  assign pop = (state == ST_IDLE) && q_valid && !out_valid && !init;

  always_comb begin
    mem_re = 1'b0;
    rd_addr = pix_addr;
    if (pop && q_data.kind == KIND_READ && read_ok) begin
      mem_re = 1'b1;
      rd_addr = ADDR_W'(q_data.read_row * SURFACE_SIZE) + ADDR_W'(q_data.read_col);
    end else if (state == ST_PIX && in_bounds && num > 0) begin
      mem_re = 1'b1;
    end
    mem_we = 1'b0;
    wr_addr = clr_addr;
    wr_val = 8'd0;
    if (state == ST_CLR) begin
      mem_we = 1'b1;
    end else if (state == ST_WR && value > rd_data) begin
      mem_we = 1'b1;
      wr_addr = rd_addr_q;
      wr_val = value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= canvas[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (mem_we) canvas[wr_addr] <= wr_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      init <= 1'b1;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            cmd <= q_data;
            out_data <= '0;
            count <= 8'd0;
            ox <= -$signed({1'b0, q_data.ext});
            oy <= -$signed({1'b0, q_data.ext});
            case (q_data.kind)
              KIND_CLEAR: begin
                clr_addr <= '0;
                state <= ST_CLR;
              end
              KIND_DRAW: state <= ST_PIX;
              KIND_READ: begin
                if (read_ok) begin
                  state <= ST_RD;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
            if (init) begin
              init <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_RD: begin
          out_data.pixel_value <= rd_data;
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        ST_PIX: begin
          if (in_bounds && num > 0) begin
            full_cov <= (num >= $signed({5'b0, cmd.span}));
            prod <= cmd.gray * num[19:0];
            state <= ST_LOAD;
          end else begin
            if (ox == ext_s) begin
              ox <= -ext_s;
              oy <= oy + 4'sd1;
            end else begin
              ox <= ox + 4'sd1;
            end
            if (last_pix) begin
              out_data.pixels_raised <= count;
              out_valid <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        ST_LOAD: begin
          if (full_cov) begin
            value <= cmd.gray;
            state <= ST_WR;
          end else begin
            rem <= {prod, 1'b0} + 29'(cmd.span);
            quot <= 8'd0;
            step <= 3'd7;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            quot[step] <= 1'b1;
          end
          step <= step - 3'd1;
          if (step == 3'd0) begin
            value <= (rem >= trial) ? (quot | 8'd1) : quot;
            state <= ST_WR;
          end
        end
        ST_WR: begin
          if (value > rd_data && count != 8'd255) count <= count + 8'd1;
          if (ox == ext_s) begin
            ox <= -ext_s;
            oy <= oy + 4'sd1;
          end else begin
            ox <= ox + 4'sd1;
          end
          if (last_pix) begin
            out_data.pixels_raised <= (value > rd_data && count != 8'd255) ?
                                      count + 8'd1 : count;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_PIX;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ADMR_ASSERT_SAME(a_we_state, mem_we, (state == ST_CLR) || (state == ST_WR))
  `ADMR_ASSERT_SAME(a_no_pop_init, init, !pop)
  `ADMR_ASSERT_NEXT(a_div_end, (state == ST_DIV) && (step == 3'd0), state == ST_WR)
  `ADMR_ASSERT_NEXT(a_count_sat, (state == ST_WR) && (count == 8'd255) && !last_pix,
                    count == 8'd255)
endmodule

// File: bench/tb_antialiased_disc_max_blend_raster_top.sv
`timescale 1ns / 1ps
module tb_antialiased_disc_max_blend_raster_top;
  import admr_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class raster_scoreboard;
    byte unsigned canvas[SURFACE_SIZE * SURFACE_SIZE];
    int unsigned radius_scale;
    int unsigned radius_min;
    int unsigned radius_max;
    int unsigned brightness_gain;
    out_t pending[$];
    int errors;

    function void reset_state();
      foreach (canvas[i]) canvas[i] = 0;
      radius_scale = 210;
      radius_min = 205;
      radius_max = 1075;
      brightness_gain = 320;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] value);
      case (idx)
        REG_RADIUS_SCALE: radius_scale = value[7:0];
        REG_RADIUS_MIN: radius_min = value[11:0];
        REG_RADIUS_MAX: radius_max = value[10:0];
        REG_BRIGHTNESS_GAIN: brightness_gain = value[9:0];
        default: ;
      endcase
    endfunction

    function longint pixel_of(logic signed [15:0] offset);
      longint c;
      c = longint'(SURFACE_SIZE) * 32 + longint'(offset);
      if (c >= 0) return (c + 32) / 64;
      return -((-c + 32) / 64);
    endfunction

    function int unsigned splat(in_t it);
      longint r, ext, cx, cy, b, gray, outer, span, num, v, x, y;
      int unsigned count;
      int idx;
      r = (longint'(it.disc_radius) * radius_scale + 128) >>> 8;
      if (r < radius_min) r = radius_min;
      if (r > radius_max) r = radius_max;
      ext = (r + 383) >>> 8;
      cx = pixel_of(it.center_dx);
      cy = pixel_of(it.center_dy);
      b = longint'(it.intensity) * brightness_gain;
      if (b > 65536) b = 65536;
      gray = (b * 255 + 32768) >>> 16;
      outer = (r + 128) * (r + 128);
      span = r * 512;
      if (span < SPAN_MIN) span = SPAN_MIN;
      count = 0;
      for (longint oy = -ext; oy <= ext; oy++) begin
        y = cy + oy;
        if (y < 0 || y >= SURFACE_SIZE) continue;
        for (longint ox = -ext; ox <= ext; ox++) begin
          x = cx + ox;
          num = outer - 65536 * (ox * ox + oy * oy);
          if (num <= 0 || x < 0 || x >= SURFACE_SIZE) continue;
          if (num >= span) v = gray;
          else v = (2 * gray * num + span) / (2 * span);
          idx = int'(y) * SURFACE_SIZE + int'(x);
          if (v > canvas[idx]) begin
            canvas[idx] = v[7:0];
            if (count < 255) count++;
          end
        end
      end
      return count;
    endfunction

    function void note_input(in_t it);
      out_t res;
      res = '0;
      case (it.kind)
        KIND_CLEAR: foreach (canvas[i]) canvas[i] = 0;
        KIND_DRAW: res.pixels_raised = 8'(splat(it));
        KIND_READ: begin
          if (it.read_col < SURFACE_SIZE && it.read_row < SURFACE_SIZE)
            res.pixel_value = canvas[it.read_row * SURFACE_SIZE + it.read_col];
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pixel_value !== want.pixel_value) begin
        $display("%0t: pixel_value mismatch, expected %0d, actual %0d",
                 $time, want.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.pixels_raised !== want.pixels_raised) begin
        $display("%0t: pixels_raised mismatch, expected %0d, actual %0d",
                 $time, want.pixels_raised, got.pixels_raised);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [11:0] cfg_data;

  raster_scoreboard sb;
  bit quiet;
  bit hold_req;
  int hold_left;
  int cycles;
  int last_col;
  int last_row;
  int n_draw;
  int n_read;
  int n_clear;

  antialiased_disc_max_blend_raster_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_config(int scale, int rmin, int rmax, int gain);
    write_reg(REG_RADIUS_SCALE, 12'(scale));
    write_reg(REG_RADIUS_MIN, 12'(rmin));
    write_reg(REG_RADIUS_MAX, 12'(rmax));
    write_reg(REG_BRIGHTNESS_GAIN, 12'(gain));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(in_t it);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    case (it.kind)
      KIND_DRAW: n_draw++;
      KIND_READ: n_read++;
      KIND_CLEAR: n_clear++;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_t draw_item(int dx, int dy, int radius, int inten);
    in_t it;
    it = in_t'({$urandom(), $urandom(), $urandom()});
    it.kind = KIND_DRAW;
    it.center_dx = 16'(dx);
    it.center_dy = 16'(dy);
    it.disc_radius = 12'(radius);
    it.intensity = 9'(inten);
    last_col = 192 + dx / 64;
    last_row = 192 + dy / 64;
    return it;
  endfunction

  function automatic in_t read_item(int col, int row);
    in_t it;
    it = in_t'({$urandom(), $urandom(), $urandom()});
    it.kind = KIND_READ;
    it.read_col = 9'(col);
    it.read_row = 9'(row);
    return it;
  endfunction

  function automatic int near(int c);
    int v;
    v = c + $urandom_range(0, 14) - 7;
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    return v;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int pick;
    int dx;
    int dy;
    pick = $urandom_range(0, 199);
    if (pick == 0) begin
      it = in_t'({$urandom(), $urandom(), $urandom()});
      it.kind = KIND_UNUSED;
    end else if (pick < 100) begin
      if ($urandom_range(0, 9) < 8) begin
        dx = $urandom_range(0, 24575) - 12288;
        dy = $urandom_range(0, 24575) - 12288;
      end else begin
        dx = $signed(16'($urandom()));
        dy = $signed(16'($urandom()));
      end
      it = draw_item(dx, dy, $urandom_range(0, 4095), $urandom_range(0, 511));
    end else if (pick < 180) begin
      it = read_item(near(last_col), near(last_row));
    end else begin
      it = read_item($urandom_range(0, 511), $urandom_range(0, 511));
    end
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 2 && i < count / 2 + 40);
      send_item(random_item());
    end
    quiet = 0;
  endtask

  initial begin
    in_t it;
    sb = new();
    sb.reset_state();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RADIUS_SCALE;
    cfg_data = '0;
    quiet = 0;
    hold_req = 0;
    hold_left = 0;
    cycles = 0;
    last_col = 192;
    last_row = 192;
    n_draw = 0;
    n_read = 0;
    n_clear = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_config(210, 205, 1075, 320);
    send_item(draw_item(0, 0, 4095, 511));
    send_item(read_item(192, 192));
    send_item(read_item(197, 192));
    send_item(draw_item(-12288, -12288, 300, 256));
    send_item(read_item(0, 0));
    send_item(draw_item(12287, 12287, 800, 200));
    send_item(read_item(383, 383));
    send_item(draw_item(32, -32, 0, 511));
    send_item(draw_item(-32768, 32767, 4095, 511));
    send_item(draw_item(32767, -32768, 2048, 511));
    send_item(read_item(384, 10));
    send_item(read_item(10, 511));
    it = in_t'({$urandom(), $urandom(), $urandom()});
    it.kind = KIND_UNUSED;
    send_item(it);
    send_item(read_item(192, 192));
    it = '0;
    it.kind = KIND_CLEAR;
    send_item(it);
    send_item(read_item(192, 192));
    send_item(draw_item(640, 640, 1000, 0));
    send_item(read_item(202, 202));
    drain();

    random_phase(190);
    drain();

    apply_config(255, 0, 1535, 1023);
    hold_req = 1;
    for (int i = 0; i < 12; i++) send_item(read_item(near(192), near(192)));
    random_phase(190);
    drain();

    apply_config(128, 4095, 700, 600);
    random_phase(190);
    it = '0;
    it.kind = KIND_CLEAR;
    send_item(it);
    drain();

    apply_config(0, 0, 0, 1);
    send_item(draw_item(0, 0, 0, 511));
    send_item(read_item(192, 192));
    random_phase(80);
    drain();

    apply_config(255, 0, 0, 1023);
    random_phase(60);
    drain();

    apply_config(0, 4095, 1535, 0);
    random_phase(30);
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d draws, %0d reads and %0d clears over six register settings,",
             n_draw, n_read, n_clear);
    $display("including radius clamp extremes, crossed clamps and a long output hold-off.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/admr_pkg.sv
rtl/admr_front.sv
rtl/admr_queue.sv
rtl/admr_back.sv
rtl/antialiased_disc_max_blend_raster_top.sv
bench/tb_antialiased_disc_max_blend_raster_top.sv
